[design/mck_pkg.sv]
// shared types, constants and the morse code table for the keyer
package mck_pkg;

   localparam int unsigned LetterCount = 26;
   localparam int unsigned LampCount   = 5;
   localparam int unsigned CodeLen     = 5;

   localparam logic [15:0] DotTimeReset   = 16'd200;
   localparam logic [15:0] DashTimeReset  = 16'd600;
   localparam logic [15:0] SymbolGapReset = 16'd200;
   localparam logic [15:0] LetterGapReset = 16'd600;
   localparam logic [15:0] WordGapReset   = 16'd1400;

   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5a;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7a;

   typedef struct packed {
      logic [7:0] character;
      logic [2:0] lamp_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  lamp_select;
      logic        lamp_on;
      logic [15:0] duration_ms;
      logic        last_segment;
   } rsp_type;

   typedef struct packed {
      logic [15:0] dot_time;
      logic [15:0] dash_time;
      logic [15:0] symbol_gap;
      logic [15:0] letter_gap;
      logic [15:0] word_gap;
   } timing_type;

   typedef enum logic [2:0] {
      CsrDotTime   = 3'd0,
      CsrDashTime  = 3'd1,
      CsrSymbolGap = 3'd2,
      CsrLetterGap = 3'd3,
      CsrWordGap   = 3'd4
   } csr_index_type;

   // microcode
   typedef logic [1:0] pc_type;

   localparam pc_type PcSymOn   = 2'd0;
   localparam pc_type PcSymOff  = 2'd1;
   localparam pc_type PcCharEnd = 2'd2;
   localparam pc_type PcSpace   = 2'd3;

   typedef enum logic [1:0] {
      DurSymbol    = 2'd0,
      DurSymbolGap = 2'd1,
      DurLetterGap = 2'd2,
      DurWordGap   = 2'd3
   } dur_sel_type;

   typedef enum logic [1:0] {
      JumpNext = 2'd0,
      JumpLoop = 2'd1,
      JumpDone = 2'd2
   } jump_type;

   typedef struct packed {
      logic        emit;
      logic        lamp_on;
      logic        last;
      dur_sel_type dur_sel;
      logic        shift;
      jump_type    jump;
      pc_type      target;
   } ctrl_word_type;

   // symbols left aligned, msb first, 1 is a dash
   typedef struct packed {
      logic [2:0]         len;
      logic [CodeLen-1:0] bits;
   } code_type;

   function automatic code_type code_lookup(input logic [5:0] idx);
      code_type c;
      unique case (idx)
         6'd0:    c = '{3'd2, 5'b01000};
         6'd1:    c = '{3'd4, 5'b10000};
         6'd2:    c = '{3'd4, 5'b10100};
         6'd3:    c = '{3'd3, 5'b10000};
         6'd4:    c = '{3'd1, 5'b00000};
         6'd5:    c = '{3'd4, 5'b00100};
         6'd6:    c = '{3'd3, 5'b11000};
         6'd7:    c = '{3'd4, 5'b00000};
         6'd8:    c = '{3'd2, 5'b00000};
         6'd9:    c = '{3'd4, 5'b01110};
         6'd10:   c = '{3'd3, 5'b10100};
         6'd11:   c = '{3'd4, 5'b01000};
         6'd12:   c = '{3'd2, 5'b11000};
         6'd13:   c = '{3'd2, 5'b10000};
         6'd14:   c = '{3'd3, 5'b11100};
         6'd15:   c = '{3'd4, 5'b01100};
         6'd16:   c = '{3'd4, 5'b11010};
         6'd17:   c = '{3'd3, 5'b01000};
         6'd18:   c = '{3'd3, 5'b00000};
         6'd19:   c = '{3'd1, 5'b10000};
         6'd20:   c = '{3'd3, 5'b00100};
         6'd21:   c = '{3'd4, 5'b00010};
         6'd22:   c = '{3'd3, 5'b01100};
         6'd23:   c = '{3'd4, 5'b10010};
         6'd24:   c = '{3'd4, 5'b10110};
         6'd25:   c = '{3'd4, 5'b11000};
         6'd26:   c = '{3'd5, 5'b11111};
         6'd27:   c = '{3'd5, 5'b01111};
         6'd28:   c = '{3'd5, 5'b00111};
         6'd29:   c = '{3'd5, 5'b00011};
         6'd30:   c = '{3'd5, 5'b00001};
         6'd31:   c = '{3'd5, 5'b00000};
         6'd32:   c = '{3'd5, 5'b10000};
         6'd33:   c = '{3'd5, 5'b11000};
         6'd34:   c = '{3'd5, 5'b11100};
         6'd35:   c = '{3'd5, 5'b11110};
         default: c = '{3'd0, 5'b00000};
      endcase
      return c;
   endfunction

endpackage

[design/mck_csr.sv]
// apb timing registers of the keyer
module mck_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output mck_pkg::timing_type timing
);
   import mck_pkg::*;

   timing_type timing_ff;
   timing_type timing_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign timing = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            CsrDotTime:   timing_in.dot_time   = pwdata[15:0];
            CsrDashTime:  timing_in.dash_time  = pwdata[15:0];
            CsrSymbolGap: timing_in.symbol_gap = pwdata[15:0];
            CsrLetterGap: timing_in.letter_gap = pwdata[15:0];
            CsrWordGap:   timing_in.word_gap   = pwdata[15:0];
            default:      timing_in = timing_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         CsrDotTime:   prdata = {16'd0, timing_ff.dot_time};
         CsrDashTime:  prdata = {16'd0, timing_ff.dash_time};
         CsrSymbolGap: prdata = {16'd0, timing_ff.symbol_gap};
         CsrLetterGap: prdata = {16'd0, timing_ff.letter_gap};
         CsrWordGap:   prdata = {16'd0, timing_ff.word_gap};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.dot_time   <= DotTimeReset;
         timing_ff.dash_time  <= DashTimeReset;
         timing_ff.symbol_gap <= SymbolGapReset;
         timing_ff.letter_gap <= LetterGapReset;
         timing_ff.word_gap   <= WordGapReset;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

[design/mck_seq.sv]
// microcoded segment sequencer with its datapath and output register
module mck_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mck_pkg::req_type    req_item,
   input  mck_pkg::timing_type timing,
   output logic                rsp_valid,
   output mck_pkg::rsp_type    rsp_data
);
   import mck_pkg::*;

   localparam ctrl_word_type Program [4] = '{
      // symbol on
      '{1'b1, 1'b1, 1'b0, DurSymbol,    1'b0, JumpNext, PcSymOn},
      // symbol gap, loop while symbols remain
      '{1'b1, 1'b0, 1'b0, DurSymbolGap, 1'b1, JumpLoop, PcSymOn},
      // letter gap closes the character
      '{1'b1, 1'b0, 1'b1, DurLetterGap, 1'b0, JumpDone, PcSymOn},
      // space
      '{1'b1, 1'b0, 1'b1, DurWordGap,   1'b0, JumpDone, PcSymOn}
   };

   logic               busy_ff,      busy_in;
   pc_type             pc_ff,        pc_in;
   logic [CodeLen-1:0] pat_ff,       pat_in;
   logic [2:0]         cnt_ff,       cnt_in;
   logic [2:0]         lamp_ff,      lamp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;

   ctrl_word_type cw;
   code_type      code;
   logic [7:0]    ch;
   logic [5:0]    idx;
   logic          is_code;
   logic          lamp_ok;
   logic          accept;
   logic [15:0]   dur;

   assign accept = start && !busy_ff;
   assign ch     = req_item.character;
   assign cw     = Program[pc_ff];

   // character to table index
   always_comb begin
      idx     = 6'd0;
      is_code = 1'b1;
      if (ch >= CharUpperA && ch <= CharUpperZ) begin
         idx = 6'(ch - CharUpperA);
      end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
         idx = 6'(ch - CharLowerA);
      end else if (ch >= CharZero && ch <= CharNine) begin
         idx = 6'(ch - CharZero) + 6'(LetterCount);
      end else begin
         is_code = 1'b0;
      end
   end

   assign code    = code_lookup(idx);
   assign lamp_ok = req_item.lamp_index < 3'(LampCount);

   always_comb begin
      unique case (cw.dur_sel)
         DurSymbol:    dur = pat_ff[CodeLen-1] ? timing.dash_time : timing.dot_time;
         DurSymbolGap: dur = timing.symbol_gap;
         DurLetterGap: dur = timing.letter_gap;
         DurWordGap:   dur = timing.word_gap;
         default:      dur = timing.dot_time;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      pat_in       = pat_ff;
      cnt_in       = cnt_ff;
      lamp_in      = lamp_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (busy_ff) begin
         if (cw.emit) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.lamp_select  = lamp_ff;
            rsp_data_in.lamp_on      = cw.lamp_on;
            rsp_data_in.duration_ms  = dur;
            rsp_data_in.last_segment = cw.last;
         end
         if (cw.shift) begin
            pat_in = {pat_ff[CodeLen-2:0], 1'b0};
            cnt_in = cnt_ff - 3'd1;
         end
         unique case (cw.jump)
            JumpNext: pc_in = pc_ff + 2'd1;
            JumpLoop: pc_in = (cnt_ff > 3'd1) ? cw.target : pc_ff + 2'd1;
            JumpDone: busy_in = 1'b0;
            default:  busy_in = 1'b0;
         endcase
      end else if (accept && lamp_ok) begin
         lamp_in = req_item.lamp_index;
         if (ch == CharSpace) begin
            busy_in = 1'b1;
            pc_in   = PcSpace;
         end else if (is_code) begin
            busy_in = 1'b1;
            pc_in   = PcSymOn;
            pat_in  = code.bits;
            cnt_in  = code.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PcSymOn;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff      <= pat_in;
      cnt_ff      <= cnt_in;
      lamp_ff     <= lamp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_beat_from_program: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy_ff))
      else $error("result beat without a running program");

   a_last_ends_program: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_segment) |-> !busy_ff)
      else $error("last segment left the sequencer running");

   a_symbols_left: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (pc_ff == PcSymOn || pc_ff == PcSymOff)) |-> cnt_ff != 3'd0)
      else $error("symbol step with no symbols left");

   a_lamp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.lamp_select < 3'(LampCount))
      else $error("segment for a lamp out of range");

endmodule

[design/morse_code_keyer.sv]
// morse code keyer top level
//
// channel   direction  handshake                 beat
// req       in         start, busy               req_item (character, lamp_index)
// rsp       out        rsp_valid strobe          rsp_data (lamp, on, duration, last)
// csr       in/out     apb psel/penable, pready  paddr, pwdata, prdata
//
// a character of n symbols gives 2n+1 segments, one each cycle; a space gives one
// busy stays high while an item's segments are stepped out, and the next item is
// taken only once busy is low; segments leave in the cycle after their step
// an item that gives no segment is taken and leaves busy low
// synchronous reset restores the default timings; rsp cannot be stalled
module morse_code_keyer (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mck_pkg::req_type req_item,
   output logic             rsp_valid,
   output mck_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import mck_pkg::*;

   timing_type timing;

   mck_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .timing  (timing)
   );

   mck_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .timing    (timing),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
